// File: design/scc_pkg.sv
// Shared constants for the sector cache clock replacement unit.
`default_nettype none

package scc_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int MODE_W        = 2;
   localparam int SECTOR_W      = 32;
   localparam int SLOT_W        = 6;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_READ  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_FLUSH = 2'd2;
   localparam mode_type MODE_CLEAR = 2'd3;

endpackage

`default_nettype wire

// File: design/sector_cache_clock_replacement_unit.sv
// Tag and clock replacement state keeper for a fully associative sector cache.
// A hit is found by a linear search from slot 0; a miss searches every slot, then runs the clock
// sweep from one past the hand, clearing reference bits until it finds a free or unreferenced slot.
// Flush and clear walk all slots, and an output stall can hold them.
// Throughput: one item at a time, one slot per cycle through the memories while the output is not stalled.
// Reset: a clearing pass writes every slot of the status memory; no item is taken meanwhile.
`default_nettype none

module sector_cache_clock_replacement_unit #(
   parameter int SLOTS = scc_pkg::SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [scc_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [scc_pkg::SECTOR_W-1:0] req_sector,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_hit,
   output      logic [scc_pkg::SLOT_W-1:0]   rsp_slot,
   output      logic                         rsp_writeback,
   output      logic [scc_pkg::SECTOR_W-1:0] rsp_writeback_sector,
   output      logic                         rsp_fill,
   output      logic                         rsp_last
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   typedef struct packed {
      logic valid;
      logic dirty;
      logic refd;
   } stat_type;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_SEARCH, ST_SWEEP, ST_SCAN, ST_FINISH
   } state_type;

   // memories
   logic [scc_pkg::SECTOR_W-1:0] tag_mem [SLOTS];
   stat_type                     stat_mem [SLOTS];
   logic [scc_pkg::SECTOR_W-1:0] tag_q;
   stat_type                     stat_q;

   logic [AW-1:0]                rd_addr;
   logic                         tag_we;
   logic                         stat_we;
   logic [AW-1:0]                stat_wa;
   stat_type                     stat_wd;

   // control and payload registers
   state_type                    state_ff, state_in;
   logic [AW-1:0]                init_ff, init_in;
   logic [AW-1:0]                cur_ff, cur_in;
   logic [AW-1:0]                hand_ff, hand_in;
   scc_pkg::mode_type            mode_ff, mode_in;
   logic [scc_pkg::SECTOR_W-1:0] sector_ff, sector_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [AW-1:0]                pend_slot_ff, pend_slot_in;
   logic [scc_pkg::SECTOR_W-1:0] pend_tag_ff, pend_tag_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [scc_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_wb_ff, rsp_wb_in;
   logic [scc_pkg::SECTOR_W-1:0] rsp_wbs_ff, rsp_wbs_in;
   logic                         rsp_fill_ff, rsp_fill_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         out_free;
   logic [AW-1:0]                cur_next;
   logic [AW-1:0]                hand_next;
   logic                         is_write;
   logic                         is_clear;
   logic                         tag_match;
   logic                         wb_here;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur_next  = (cur_ff == LAST_SLOT) ? '0 : cur_ff + AW'(1);
   assign hand_next = (hand_ff == LAST_SLOT) ? '0 : hand_ff + AW'(1);
   assign is_write  = (mode_ff == scc_pkg::MODE_WRITE);
   assign is_clear  = (mode_ff == scc_pkg::MODE_CLEAR);
   assign tag_match = stat_q.valid && (tag_q == sector_ff);
   assign wb_here   = stat_q.valid && stat_q.dirty;

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[cur_ff] <= sector_ff;
      end
      tag_q <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[stat_wa] <= stat_wd;
      end
      stat_q <= stat_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cur_in        = cur_ff;
      hand_in       = hand_ff;
      mode_in       = mode_ff;
      sector_in     = sector_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      rd_addr       = cur_ff;
      tag_we        = 1'b0;
      stat_we       = 1'b0;
      stat_wa       = cur_ff;
      stat_wd       = '0;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_wbs_in    = rsp_wbs_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_INIT: begin
            stat_we = 1'b1;
            stat_wa = init_ff;
            if (init_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            rd_addr = '0;
            cur_in  = '0;
            if (req_valid) begin
               mode_in       = req_mode;
               sector_in     = req_sector;
               pend_valid_in = 1'b0;
               case (req_mode) inside
                  scc_pkg::MODE_READ, scc_pkg::MODE_WRITE: state_in = ST_SEARCH;
                  default:                                 state_in = ST_SCAN;
               endcase
            end
         end

         ST_SEARCH: begin
            if (tag_match) begin
               if (out_free) begin
                  stat_we      = 1'b1;
                  stat_wd      = '{valid: 1'b1, dirty: stat_q.dirty | is_write, refd: 1'b1};
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b1;
                  rsp_slot_in  = scc_pkg::SLOT_W'(cur_ff);
                  rsp_wb_in    = 1'b0;
                  rsp_wbs_in   = '0;
                  rsp_fill_in  = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (cur_ff == LAST_SLOT) begin
               // miss: start the clock sweep one past the hand
               rd_addr  = hand_next;
               cur_in   = hand_next;
               state_in = ST_SWEEP;
            end else begin
               rd_addr = cur_next;
               cur_in  = cur_next;
            end
         end

         ST_SWEEP: begin
            if (!stat_q.valid || !stat_q.refd) begin
               if (out_free) begin
                  tag_we       = 1'b1;
                  stat_we      = 1'b1;
                  stat_wd      = '{valid: 1'b1, dirty: is_write, refd: 1'b1};
                  hand_in      = cur_ff;
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_slot_in  = scc_pkg::SLOT_W'(cur_ff);
                  rsp_wb_in    = wb_here;
                  rsp_wbs_in   = wb_here ? tag_q : '0;
                  rsp_fill_in  = !is_write;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               // second chance: drop the reference bit and advance
               stat_we = 1'b1;
               stat_wd = '{valid: stat_q.valid, dirty: stat_q.dirty, refd: 1'b0};
               rd_addr = cur_next;
               cur_in  = cur_next;
            end
         end

         ST_SCAN: begin
            // hold a stalled slot until the previous writeback can go out
            if (!(wb_here && pend_valid_ff && !out_free)) begin
               stat_we = 1'b1;
               stat_wd = is_clear ? stat_type'('0)
                                  : '{valid: stat_q.valid, dirty: 1'b0, refd: stat_q.refd};
               if (wb_here) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b0;
                     rsp_slot_in  = scc_pkg::SLOT_W'(pend_slot_ff);
                     rsp_wb_in    = 1'b1;
                     rsp_wbs_in   = pend_tag_ff;
                     rsp_fill_in  = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = cur_ff;
                  pend_tag_in   = tag_q;
               end
               if (cur_ff == LAST_SLOT) begin
                  state_in = ST_FINISH;
               end else begin
                  rd_addr = cur_next;
                  cur_in  = cur_next;
               end
            end
         end

         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_slot_in  = scc_pkg::SLOT_W'(pend_slot_ff);
                  rsp_wb_in    = 1'b1;
                  rsp_wbs_in   = pend_tag_ff;
                  rsp_fill_in  = 1'b0;
                  rsp_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               if (is_clear) begin
                  hand_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_ff       <= '0;
         hand_ff       <= LAST_SLOT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         hand_ff       <= hand_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      mode_ff      <= mode_in;
      sector_ff    <= sector_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_wbs_ff   <= rsp_wbs_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_writeback        = rsp_wb_ff;
   assign rsp_writeback_sector = rsp_wbs_ff;
   assign rsp_fill             = rsp_fill_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

`default_nettype wire
